>>> rtl/hcd_pkg.sv
`default_nettype none

package hcd_pkg;

   // held-set depth and derived widths
   localparam int MAX_KEYS  = 4;
   localparam int IDX_W     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W     = $clog2(MAX_KEYS + 1);

   // fixed field widths
   localparam int KEY_W      = 9;
   localparam int SIZE_W     = 3;
   localparam int CNT_OUT_W  = 3;
   localparam int TGT_SLOTS  = 4;
   localparam int TGT_IDX_W  = 2;
   localparam int TGT_CNT_W  = 3;
   localparam int CMP_W      = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [TGT_CNT_W-1:0] TGT_SLOTS_C  = TGT_CNT_W'(TGT_SLOTS);
   localparam logic [SIZE_W-1:0]    SIZE_RST     = 3'd1;
   localparam logic [KEY_W-1:0]     KEY_A_RST    = 9'h11D;
   localparam logic [KEY_W-1:0]     KEY_OTHER_RST = 9'h000;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COMBO_SIZE  = 3'd0,
      REG_COMBO_KEY_A = 3'd1,
      REG_COMBO_KEY_B = 3'd2,
      REG_COMBO_KEY_C = 3'd3,
      REG_COMBO_KEY_D = 3'd4,
      REG_PAUSED      = 3'd5
   } csr_reg_type;

   typedef enum logic [1:0] {
      CMD_OTHER = 2'd0,
      CMD_DOWN  = 2'd1,
      CMD_UP    = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] scan_code;
      logic       extended;
   } req_type;

   typedef struct packed {
      logic                 press_pulse;
      logic                 release_pulse;
      logic                 combo_held;
      logic [CNT_OUT_W-1:0] held_count;
   } rsp_type;

   typedef struct packed {
      logic [SIZE_W-1:0]           combo_size;
      key_type [TGT_SLOTS-1:0]     combo_keys;
      logic                        paused;
   } cfg_type;

   // command from the sequencer to the held-key store
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      key_type          wr_data;
      logic             inc;
      logic             dec;
      logic             clr;
   } store_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DN_SCAN,
      ST_DN_MATCH,
      ST_UP_TGT,
      ST_UP_FIND,
      ST_UP_SHIFT,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/hotkey_combo_detector.sv
`default_nettype none

// Channel   Ports                               Direction  Word
// --------  ----------------------------------  ---------  ---------------------------
// request   req_valid, req_ready, req_word      in         cmd, scan_code, extended
// response  rsp_valid, rsp_ready, rsp_word      out        press/release, held, count
// csr       csr_wr_en, csr_index, csr_wdata     in         6 registers, write only
//
// One word at a time through a shared 9-bit key comparator; req_ready is high only
// while the sequencer is idle. A key down scans the held set for the key, then looks
// up each of the S target keys (S <= 4) in it; a key up checks the targets, finds the
// key in the set and shifts the later entries down. Other and paused words skip both.
// A finished word waits in the response register; the next request is taken
// meanwhile, and its result waits in the sequencer until the register frees.
// Reset is synchronous and restores the configuration defaults and an empty set.
module hotkey_combo_detector (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire hcd_pkg::req_type                 req_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output hcd_pkg::rsp_type                      rsp_word,
   input  wire logic                             csr_wr_en,
   input  wire logic [hcd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [hcd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   hcd_pkg::cfg_type                  cfg_ff, cfg_in;
   logic                              cfg_clr;

   logic                              rsp_valid_ff, rsp_valid_in;
   hcd_pkg::rsp_type                  rsp_word_ff, rsp_word_in;

   logic                              req_fire;
   logic                              out_free;
   logic                              res_load;
   hcd_pkg::rsp_type                  res_word;
   hcd_pkg::store_cmd_type            store_cmd;
   logic [hcd_pkg::IDX_W-1:0]         rd_idx;
   hcd_pkg::key_type                  rd_data;
   logic [hcd_pkg::CNT_W-1:0]         total;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // CSR decode; combination writes also empty the held set
   always_comb begin
      cfg_in  = cfg_ff;
      cfg_clr = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            hcd_pkg::REG_COMBO_SIZE: begin
               cfg_in.combo_size = csr_wdata[hcd_pkg::SIZE_W-1:0];
               cfg_clr           = 1'b1;
            end
            hcd_pkg::REG_COMBO_KEY_A: begin
               cfg_in.combo_keys[0] = csr_wdata[hcd_pkg::KEY_W-1:0];
               cfg_clr              = 1'b1;
            end
            hcd_pkg::REG_COMBO_KEY_B: begin
               cfg_in.combo_keys[1] = csr_wdata[hcd_pkg::KEY_W-1:0];
               cfg_clr              = 1'b1;
            end
            hcd_pkg::REG_COMBO_KEY_C: begin
               cfg_in.combo_keys[2] = csr_wdata[hcd_pkg::KEY_W-1:0];
               cfg_clr              = 1'b1;
            end
            hcd_pkg::REG_COMBO_KEY_D: begin
               cfg_in.combo_keys[3] = csr_wdata[hcd_pkg::KEY_W-1:0];
               cfg_clr              = 1'b1;
            end
            hcd_pkg::REG_PAUSED: begin
               cfg_in.paused = csr_wdata[0];
            end
            default: begin
               cfg_clr = 1'b0;   // unknown index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.combo_size    <= hcd_pkg::SIZE_RST;
         cfg_ff.combo_keys[0] <= hcd_pkg::KEY_A_RST;
         cfg_ff.combo_keys[1] <= hcd_pkg::KEY_OTHER_RST;
         cfg_ff.combo_keys[2] <= hcd_pkg::KEY_OTHER_RST;
         cfg_ff.combo_keys[3] <= hcd_pkg::KEY_OTHER_RST;
         cfg_ff.paused        <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = res_word;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   hcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .clr       (cfg_clr),
      .req_fire  (req_fire),
      .req_word  (req_word),
      .req_ready (req_ready),
      .out_free  (out_free),
      .res_load  (res_load),
      .res_word  (res_word),
      .store_cmd (store_cmd),
      .rd_idx    (rd_idx),
      .rd_data   (rd_data),
      .total     (total)
   );

   hcd_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .rd_idx  (rd_idx),
      .rd_data (rd_data),
      .total   (total)
   );

endmodule

`default_nettype wire

>>> rtl/hcd_store.sv
`default_nettype none

// held-key set: entry registers, one read port, one write port, fill count
module hcd_store (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire hcd_pkg::store_cmd_type   cmd,
   input  wire logic [hcd_pkg::IDX_W-1:0] rd_idx,
   output hcd_pkg::key_type              rd_data,
   output logic [hcd_pkg::CNT_W-1:0]     total
);

   hcd_pkg::key_type                 held_ff [hcd_pkg::MAX_KEYS];
   logic [hcd_pkg::CNT_W-1:0]        total_ff;
   logic [hcd_pkg::CNT_W-1:0]        total_in;

   always_comb begin
      priority if (cmd.clr) begin
         total_in = '0;
      end else if (cmd.inc) begin
         total_in = total_ff + hcd_pkg::CNT_W'(1);
      end else if (cmd.dec) begin
         total_in = total_ff - hcd_pkg::CNT_W'(1);
      end else begin
         total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   // entries are undefined until written; only the filled part is read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         held_ff[cmd.wr_idx] <= cmd.wr_data;
      end
   end

   assign rd_data = held_ff[rd_idx];
   assign total   = total_ff;

endmodule

`default_nettype wire

>>> rtl/hcd_ctrl.sv
`default_nettype none

// sequencer around one shared 9-bit key comparator
module hcd_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hcd_pkg::cfg_type          cfg,
   input  wire logic                      clr,
   input  wire logic                      req_fire,
   input  wire hcd_pkg::req_type          req_word,
   output logic                           req_ready,
   input  wire logic                      out_free,
   output logic                           res_load,
   output hcd_pkg::rsp_type               res_word,
   output hcd_pkg::store_cmd_type         store_cmd,
   output logic [hcd_pkg::IDX_W-1:0]      rd_idx,
   input  wire hcd_pkg::key_type          rd_data,
   input  wire logic [hcd_pkg::CNT_W-1:0] total
);

   hcd_pkg::state_type              state_ff, state_in;
   hcd_pkg::key_type                key_ff, key_in;
   logic [hcd_pkg::CNT_W-1:0]       i_ff, i_in;
   logic [hcd_pkg::TGT_CNT_W-1:0]   t_ff, t_in;
   logic                            press_ff, press_in;
   logic                            release_ff, release_in;
   logic                            active_ff, active_in;

   logic [hcd_pkg::TGT_CNT_W-1:0]   tgt_len;
   hcd_pkg::key_type                tgt_sel;
   hcd_pkg::key_type                op_a, op_b;
   logic                            eq;
   logic [hcd_pkg::CNT_W-1:0]       i_nxt;
   logic                            i_end;
   logic                            t_end;
   logic                            size_ok;

   // combo_size above the slot count counts as all slots
   assign tgt_len = (cfg.combo_size > hcd_pkg::TGT_SLOTS_C) ?
                    hcd_pkg::TGT_SLOTS_C : cfg.combo_size;
   assign tgt_sel = cfg.combo_keys[t_ff[hcd_pkg::TGT_IDX_W-1:0]];
   assign i_nxt   = i_ff + hcd_pkg::CNT_W'(1);
   assign i_end   = (i_ff == total);
   assign t_end   = (t_ff == tgt_len);
   assign size_ok = (hcd_pkg::CMP_W'(total) == hcd_pkg::CMP_W'(cfg.combo_size));

   // the shared compare unit
   assign op_a = (state_ff == hcd_pkg::ST_UP_TGT)   ? tgt_sel : rd_data;
   assign op_b = (state_ff == hcd_pkg::ST_DN_MATCH) ? tgt_sel : key_ff;
   assign eq   = (op_a == op_b);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (cfg.paused) begin
                  state_in = hcd_pkg::ST_DONE;
               end else if (req_word.cmd == hcd_pkg::CMD_DOWN) begin
                  state_in = hcd_pkg::ST_DN_SCAN;
               end else if (req_word.cmd == hcd_pkg::CMD_UP) begin
                  state_in = hcd_pkg::ST_UP_TGT;
               end else begin
                  state_in = hcd_pkg::ST_DONE;
               end
            end
         end
         hcd_pkg::ST_DN_SCAN: begin
            if (i_end || eq) begin
               state_in = hcd_pkg::ST_DN_MATCH;
            end
         end
         hcd_pkg::ST_DN_MATCH: begin
            if (!size_ok || t_end || i_end) begin
               state_in = hcd_pkg::ST_DONE;
            end
         end
         hcd_pkg::ST_UP_TGT: begin
            if (!active_ff || t_end || eq) begin
               state_in = hcd_pkg::ST_UP_FIND;
            end
         end
         hcd_pkg::ST_UP_FIND: begin
            priority if (i_end) begin
               state_in = hcd_pkg::ST_DONE;
            end else if (eq) begin
               state_in = hcd_pkg::ST_UP_SHIFT;
            end
         end
         hcd_pkg::ST_UP_SHIFT: begin
            if (!(i_nxt < total)) begin
               state_in = hcd_pkg::ST_DONE;
            end
         end
         hcd_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = hcd_pkg::ST_IDLE;
            end
         end
         default: state_in = hcd_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      key_in     = key_ff;
      i_in       = i_ff;
      t_in       = t_ff;
      press_in   = press_ff;
      release_in = release_ff;
      active_in  = active_ff;
      store_cmd  = '0;
      rd_idx     = i_ff[hcd_pkg::IDX_W-1:0];
      req_ready  = 1'b0;
      res_load   = 1'b0;
      unique case (state_ff)
         hcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               key_in     = {req_word.extended, req_word.scan_code};
               i_in       = '0;
               t_in       = '0;
               press_in   = 1'b0;
               release_in = 1'b0;
            end
         end
         hcd_pkg::ST_DN_SCAN: begin
            priority if (i_end) begin
               // not held: append when there is room
               if (total < hcd_pkg::CNT_W'(hcd_pkg::MAX_KEYS)) begin
                  store_cmd.wr_en   = 1'b1;
                  store_cmd.wr_idx  = total[hcd_pkg::IDX_W-1:0];
                  store_cmd.wr_data = key_ff;
                  store_cmd.inc     = 1'b1;
               end
               i_in = '0;
            end else if (eq) begin
               i_in = '0;
            end else begin
               i_in = i_nxt;
            end
         end
         hcd_pkg::ST_DN_MATCH: begin
            // every target key must be found in the held set
            if (size_ok) begin
               priority if (t_end) begin
                  if (!active_ff) begin
                     active_in = 1'b1;
                     press_in  = 1'b1;
                  end
               end else if (i_end) begin
                  i_in = i_ff;
               end else if (eq) begin
                  t_in = t_ff + hcd_pkg::TGT_CNT_W'(1);
                  i_in = '0;
               end else begin
                  i_in = i_nxt;
               end
            end
         end
         hcd_pkg::ST_UP_TGT: begin
            if (active_ff && !t_end) begin
               if (eq) begin
                  active_in  = 1'b0;
                  release_in = 1'b1;
               end else begin
                  t_in = t_ff + hcd_pkg::TGT_CNT_W'(1);
               end
            end
         end
         hcd_pkg::ST_UP_FIND: begin
            if (!i_end && !eq) begin
               i_in = i_nxt;
            end
         end
         hcd_pkg::ST_UP_SHIFT: begin
            // close the gap one entry a cycle
            rd_idx = i_nxt[hcd_pkg::IDX_W-1:0];
            if (i_nxt < total) begin
               store_cmd.wr_en   = 1'b1;
               store_cmd.wr_idx  = i_ff[hcd_pkg::IDX_W-1:0];
               store_cmd.wr_data = rd_data;
               i_in              = i_nxt;
            end else begin
               store_cmd.dec = 1'b1;
            end
         end
         hcd_pkg::ST_DONE: begin
            res_load = out_free;
         end
         default: begin
            res_load = 1'b0;
         end
      endcase
      store_cmd.clr = clr;
      if (clr) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= hcd_pkg::ST_IDLE;
         active_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      i_ff       <= i_in;
      t_ff       <= t_in;
      press_ff   <= press_in;
      release_ff <= release_in;
   end

   assign res_word.press_pulse   = press_ff;
   assign res_word.release_pulse = release_ff;
   assign res_word.combo_held    = active_ff;
   assign res_word.held_count    = hcd_pkg::CNT_OUT_W'(total);

   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      res_load |-> !(press_ff && release_ff))
      else $error("press and release pulse in one word");

   a_clr_drops_active: assert property (@(posedge clock) disable iff (reset)
      clr |=> !active_ff)
      else $error("combo still active after combination write");

   a_fire_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != hcd_pkg::ST_IDLE))
      else $error("sequencer stayed idle after accepting a word");

   a_release_inactive: assert property (@(posedge clock) disable iff (reset)
      (res_load && release_ff) |-> !active_ff)
      else $error("release pulse with combo still active");

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import hcd_pkg::*;

   // codes the package does not name
   localparam logic [1:0]           CMD_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_6  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_7  = 3'd7;

   // receiver stall modes
   localparam int STALL_NONE     = 0;
   localparam int STALL_COIN     = 1;
   localparam int STALL_PERIODIC = 2;
   localparam int STALL_LONG     = 3;

   // cycles with no word moving on either channel before we give up;
   // worst legal gap is roughly sender gap + busy time of one word + receiver stall
   localparam int STALL_LIMIT = 2000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   hotkey_combo_detector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Combo tracker: mirror of the block's configuration and held set
   // ---------------------------------------------------------------
   logic [SIZE_W-1:0] combo_size_q = SIZE_RST;
   key_type           combo_key_q [TGT_SLOTS] = '{KEY_A_RST, KEY_OTHER_RST,
                                                  KEY_OTHER_RST, KEY_OTHER_RST};
   logic              paused_q = 1'b0;
   key_type           held_keys_q [MAX_KEYS];
   int                held_n   = 0;
   logic              active_q = 1'b0;

   req_type pending_req [$];    // words waiting for the driver
   rsp_type expected_rsp [$];   // predicted responses, oldest first
   int      queued_total = 0;
   int      errors       = 0;

   // random keys used as distractors, picked per configuration
   key_type spare_keys [2];
   // scratch sequence of keys for the stimulus generator
   key_type seq_keys [8];
   int      seq_len;

   function automatic logic key_held(input key_type k);
      int   i;
      logic hit;
      hit = 1'b0;
      for (i = 0; i < held_n; i++)
         if (held_keys_q[i] == k) hit = 1'b1;
      return hit;
   endfunction

   // advance the tracker by one accepted word, return its response
   function automatic rsp_type predict_rsp(input req_type w);
      key_type k;
      rsp_type r;
      int      tgt_len, i, j, pos;
      logic    full_match, hit;
      k = {w.extended, w.scan_code};
      r = '0;
      // sizes above four compare as four keys, but the count check keeps the raw size
      tgt_len = (combo_size_q > 3'd4) ? 4 : int'(combo_size_q);
      if (!paused_q) begin
         if (w.cmd == CMD_DOWN) begin
            // full set and already-held key both leave the set alone
            if (held_n < MAX_KEYS && !key_held(k)) begin
               held_keys_q[held_n] = k;
               held_n++;
            end
            full_match = (held_n == int'(combo_size_q));
            for (i = 0; i < tgt_len; i++)
               if (!key_held(combo_key_q[i])) full_match = 1'b0;
            if (full_match && !active_q) begin
               active_q      = 1'b1;
               r.press_pulse = 1'b1;
            end
         end else if (w.cmd == CMD_UP) begin
            hit = 1'b0;
            for (i = 0; i < tgt_len; i++)
               if (combo_key_q[i] == k) hit = active_q;
            pos = -1;
            for (i = 0; i < held_n; i++)
               if (pos < 0 && held_keys_q[i] == k) pos = i;
            if (pos >= 0) begin
               for (j = pos; j < held_n - 1; j++)
                  held_keys_q[j] = held_keys_q[j + 1];
               held_n--;
            end
            if (hit) begin
               active_q        = 1'b0;
               r.release_pulse = 1'b1;
            end
         end
      end
      r.combo_held = active_q;
      r.held_count = 3'(held_n);
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Register writes: only issued while nothing is in flight
   // ---------------------------------------------------------------
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         REG_COMBO_SIZE: begin
            combo_size_q = data[SIZE_W-1:0];
            held_n       = 0;
            active_q     = 1'b0;
         end
         REG_COMBO_KEY_A, REG_COMBO_KEY_B, REG_COMBO_KEY_C, REG_COMBO_KEY_D: begin
            combo_key_q[idx - REG_COMBO_KEY_A] = data;
            held_n   = 0;
            active_q = 1'b0;
         end
         REG_PAUSED: paused_q = data[0];
         default: ;   // unmapped index, ignored
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // upper data bits are junk on purpose: the block must mask them
   task automatic configure(input logic [SIZE_W-1:0] size, input key_type ka, input key_type kb,
                            input key_type kc, input key_type kd);
      write_csr(REG_COMBO_SIZE, {6'($urandom), size});
      write_csr(REG_COMBO_KEY_A, ka);
      write_csr(REG_COMBO_KEY_B, kb);
      write_csr(REG_COMBO_KEY_C, kc);
      write_csr(REG_COMBO_KEY_D, kd);
      write_csr(REG_SPARE_6, 9'($urandom));
      write_csr(REG_SPARE_7, 9'($urandom));
      spare_keys[0] = 9'($urandom);
      spare_keys[1] = 9'($urandom);
   endtask

   task automatic set_paused(input logic p);
      write_csr(REG_PAUSED, {8'($urandom), p});
   endtask

   task automatic wait_idle();
      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic push_key(input logic [1:0] cmd, input key_type k);
      req_type w;
      w.cmd       = cmd;
      w.scan_code = k[7:0];
      w.extended  = k[8];
      pending_req.push_back(w);
      queued_total++;
   endtask

   task automatic shuffle_seq();
      int      i, j;
      key_type t;
      for (i = seq_len - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         t = seq_keys[i];
         seq_keys[i] = seq_keys[j];
         seq_keys[j] = t;
      end
   endtask

   // mostly press-then-release of the combo in random order; the rest is
   // single noise words, broken sequences and release sweeps
   task automatic gen_items(input int count);
      int      stop_at, tgt_len, kind, cut, i, pick;
      logic [1:0] cmd;
      key_type k;
      stop_at = queued_total + count;
      tgt_len = (combo_size_q > 3'd4) ? 4 : int'(combo_size_q);
      while (queued_total < stop_at) begin
         kind = $urandom_range(0, 9);
         for (i = 0; i < tgt_len; i++) seq_keys[i] = combo_key_q[i];
         seq_len = tgt_len;
         if (kind < 6 && tgt_len > 0) begin
            if ($urandom_range(0, 4) == 0) begin
               seq_keys[seq_len] = spare_keys[$urandom_range(0, 1)];
               seq_len++;
            end
            shuffle_seq();
            for (i = 0; i < seq_len; i++) push_key(CMD_DOWN, seq_keys[i]);
            if ($urandom_range(0, 3) == 0)
               push_key(CMD_DOWN, seq_keys[$urandom_range(0, seq_len - 1)]);
            shuffle_seq();
            // now and then leave one key held
            if ($urandom_range(0, 4) == 0) seq_len--;
            for (i = 0; i < seq_len; i++) push_key(CMD_UP, seq_keys[i]);
         end else if (kind < 8) begin
            cmd  = 2'($urandom_range(0, 3));
            pick = $urandom_range(0, 5);
            k    = (pick < 4) ? combo_key_q[pick] : spare_keys[pick - 4];
            // downs stay within the pool so the set does not clog up
            if (cmd != CMD_DOWN && $urandom_range(0, 1) == 0) k = 9'($urandom);
            push_key(cmd, k);
         end else if (kind == 8 && tgt_len > 0) begin
            // press part, drop one, press the rest
            shuffle_seq();
            cut = $urandom_range(0, seq_len - 1);
            for (i = 0; i <= cut; i++) push_key(CMD_DOWN, seq_keys[i]);
            push_key(CMD_UP, seq_keys[$urandom_range(0, cut)]);
            for (i = cut + 1; i < seq_len; i++) push_key(CMD_DOWN, seq_keys[i]);
         end else begin
            for (i = 0; i < TGT_SLOTS; i++) push_key(CMD_UP, combo_key_q[i]);
            push_key(CMD_UP, spare_keys[0]);
            push_key(CMD_UP, spare_keys[1]);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words on the reset combo (one extended key)
      push_key(CMD_OTHER,  9'h1FF);
      push_key(CMD_UNUSED, 9'h000);
      push_key(CMD_UP,     9'h11D);   // up of a key not held
      push_key(CMD_DOWN,   9'h11D);   // press
      push_key(CMD_DOWN,   9'h11D);   // repeat down, already active
      push_key(CMD_UP,     9'h01D);   // same scan, not extended: not a target
      push_key(CMD_OTHER,  9'h11D);
      push_key(CMD_UP,     9'h11D);   // release
      push_key(CMD_UP,     9'h11D);
      push_key(CMD_DOWN,   9'h000);
      push_key(CMD_DOWN,   9'h0FF);
      push_key(CMD_DOWN,   9'h1FF);
      push_key(CMD_DOWN,   9'h100);
      push_key(CMD_DOWN,   9'h11D);   // set full
      push_key(CMD_DOWN,   9'h0AA);
      push_key(CMD_UP,     9'h0FF);   // close up from the middle
      push_key(CMD_UP,     9'h000);   // and from the front
      push_key(CMD_DOWN,   9'h11D);
      push_key(CMD_UP,     9'h100);
      push_key(CMD_UP,     9'h1FF);   // only target left, no down yet
      push_key(CMD_DOWN,   9'h11D);   // repeat down completes the match
      push_key(CMD_UP,     9'h11D);
      wait_idle();

      configure(3'd2, 9'($urandom), 9'($urandom), 9'h000, 9'h000);
      set_paused(1'b0);
      gen_items(80);
      wait_idle();

      // all-zero and all-ones keys in a full combo
      configure(3'd4, 9'h000, 9'h1FF, 9'($urandom), 9'($urandom));
      gen_items(100);
      wait_idle();

      configure(3'd3, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      gen_items(80);
      wait_idle();

      // empty combo: never presses
      configure(3'd0, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      gen_items(60);
      wait_idle();

      // oversized combos: count never reaches the size
      configure(3'd7, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      gen_items(60);
      wait_idle();
      configure(3'd5, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      gen_items(40);
      wait_idle();

      // repeated target key
      configure(3'd3, 9'h0A5, 9'h0A5, 9'h15A, 9'($urandom));
      gen_items(80);
      wait_idle();

      // pause with a key held; the pause write must not clear it
      configure(3'd2, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      push_key(CMD_DOWN, combo_key_q[0]);
      wait_idle();
      set_paused(1'b1);
      gen_items(30);
      wait_idle();
      set_paused(1'b0);
      gen_items(60);
      wait_idle();

      configure(3'd1, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      gen_items(80);
      wait_idle();
      configure(3'd4, 9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom));
      gen_items(100);
      wait_idle();

      // drain: anything arriving now is unexpected
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // Driver: bursts of words with random gaps between them
   // ---------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at acceptance, with the config in force at that edge
         if (req_valid && req_ready) expected_rsp.push_back(predict_rsp(req_word));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_word  <= pending_req.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  // one burst in four runs long and back to back
                  if ($urandom_range(0, 3) == 0) begin
                     burst_left <= $urandom_range(20, 40);
                     gap_left   <= 0;
                  end else begin
                     burst_left <= $urandom_range(1, 8);
                     gap_left   <= $urandom_range(0, 12);
                  end
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Monitor: receiver stalls follow a mode that changes now and then
   // ---------------------------------------------------------------
   int stall_mode = STALL_NONE;
   int mode_left  = 0;
   int hold_left  = 0;
   int tick       = 0;

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %p", $time, rsp_word);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               check_field("press_pulse",   want.press_pulse,   rsp_word.press_pulse);
               check_field("release_pulse", want.release_pulse, rsp_word.release_pulse);
               check_field("combo_held",    want.combo_held,    rsp_word.combo_held);
               check_field("held_count",    want.held_count,    rsp_word.held_count);
            end
         end
         tick <= tick + 1;
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_LONG);
            mode_left  <= $urandom_range(20, 120);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:     rsp_ready <= 1'b1;
            STALL_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: rsp_ready <= (tick % 4 == 0);
            default: begin
               if (hold_left > 0) begin
                  hold_left <= hold_left - 1;
                  rsp_ready <= 1'b0;
               end else begin
                  hold_left <= $urandom_range(1, 16);
                  rsp_ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: cycles with no word moved on either channel
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
